/* rtl/core/jsu_pkg.sv */
package jsu_pkg;

    // Depth of the queue between the decoder and the byte serializer.
    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    // Closing status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_CAPACITY  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       byte_present;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] status;
    } t_out;

    // One decoded request: up to four output bytes, plus closing info.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n_bytes;
        logic            last;
        logic [1:0]      status;
    } t_grp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_st;

endpackage

/* rtl/core/json_string_unescape_top.sv */
// A taken request's group enters the queue, then the output register once the register is free.
// Throughput: one request per cycle while the queue has room and each gives one result;
// the serializer drains a byte per cycle while its output is popped or empty; a \u escape
// of 2..4 bytes holds the input once the 4-entry decoder-to-serializer queue fills.
// Reset: synchronous, active low; clears decoder state, empties the queue and the output
// register and restores the capacity register to 65535.
module json_string_unescape_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    input  logic          i_push,
    output logic          o_full,
    input  jsu_pkg::t_in  i_in,
    output logic          o_empty,
    input  logic          i_pop,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    t_grp  grp_in, grp_out;
    t_q_st q_st;
    logic  accept;
    logic  grp_push;
    logic  grp_pop;

    // Take a request whenever the queue has room; the decoder state advances at once.
    assign o_full = q_st.full;
    assign accept = i_push && !q_st.full;

    // Front: decode escapes, check capacity, build one group per request that yields bytes or closes the string.
    jsu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_in         (i_in),
        .o_push       (grp_push),
        .o_grp        (grp_in)
    );

    // Hold decoded groups so decoder and serializer stall independently.
    jsu_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (grp_push),
        .i_data (grp_in),
        .i_pop  (grp_pop),
        .o_data (grp_out),
        .o_st   (q_st)
    );

    // Back: emit group bytes one per cycle into the output register while it is free or popped.
    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp      (grp_out),
        .i_grp_valid(!q_st.empty),
        .o_grp_pop  (grp_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out      (o_out)
    );

    // A status-only result always closes a string.
    a_status_only_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_out.byte_valid) |-> o_out.string_done)
        else $error("status-only result without string_done");

    // Nonzero status only on a closing status-only result.
    a_status_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.status != ST_OK) |-> (o_out.string_done && !o_out.byte_valid))
        else $error("error status on a data result");

    // The decoder never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grp_push |-> !q_st.full)
        else $error("group pushed into full queue");

    // The serializer never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grp_pop |-> !q_st.empty)
        else $error("group popped from empty queue");

endmodule

/* rtl/core/jsu_front.sv */
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    input  logic          i_accept,
    input  jsu_pkg::t_in  i_in,
    output logic          o_push,
    output jsu_pkg::t_grp o_grp
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [3:0] {
        PH_PLAIN,
        PH_ESC,
        PH_HEX_HI,
        PH_WANT_BSL,
        PH_WANT_U,
        PH_HEX_LO
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_enc;

    function automatic t_hex hex_dec(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_enc utf8_enc(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.n    = 3'd2;
        end else if (cp < 21'h10000) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

    logic [15:0] r_cap;
    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_hs, n_hs;
    logic [15:0] r_bw, n_bw;
    logic [1:0]  r_err, n_err;

    t_enc        enc;
    t_hex        hx;
    logic [15:0] acc_new;
    logic [16:0] sum;
    logic [7:0]  c;

    assign c       = i_in.in_byte;
    assign hx      = hex_dec(c);
    assign acc_new = {r_acc[11:0], hx.val};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hs    = r_hs;
        n_bw    = r_bw;
        n_err   = r_err;
        enc     = '0;

        if (i_in.byte_present && r_err == ST_OK) begin
            unique case (r_phase)
                PH_ESC: begin
                    n_phase = PH_PLAIN;
                    unique case (c) inside
                        CH_QUOTE, CH_BSL, CH_SLASH: begin
                            enc.b[0] = c;
                            enc.n    = 3'd1;
                        end
                        CH_B: begin enc.b[0] = 8'h08; enc.n = 3'd1; end
                        CH_F: begin enc.b[0] = 8'h0C; enc.n = 3'd1; end
                        CH_N: begin enc.b[0] = 8'h0A; enc.n = 3'd1; end
                        CH_R: begin enc.b[0] = 8'h0D; enc.n = 3'd1; end
                        CH_T: begin enc.b[0] = 8'h09; enc.n = 3'd1; end
                        CH_U: begin
                            n_phase = PH_HEX_HI;
                            n_acc   = '0;
                            n_cnt   = '0;
                        end
                        default: n_err = ST_MALFORMED;
                    endcase
                end
                PH_HEX_HI, PH_HEX_LO: begin
                    if (!hx.ok) begin
                        n_err   = ST_MALFORMED;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_acc = acc_new;
                        if (r_cnt == 2'd3) begin
                            n_cnt = '0;
                            if (r_phase == PH_HEX_HI) begin
                                if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                                    n_hs    = acc_new[9:0];
                                    n_phase = PH_WANT_BSL;
                                end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
                                    n_err   = ST_MALFORMED;
                                    n_phase = PH_PLAIN;
                                end else begin
                                    n_phase = PH_PLAIN;
                                    enc     = utf8_enc({5'd0, acc_new});
                                end
                            end else begin
                                n_phase = PH_PLAIN;
                                if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                                    n_err = ST_MALFORMED;
                                end else begin
                                    enc = utf8_enc(21'h10000 + {1'b0, r_hs, acc_new[9:0]});
                                end
                            end
                        end else begin
                            n_cnt = r_cnt + 2'd1;
                        end
                    end
                end
                PH_WANT_BSL: begin
                    if (c != CH_BSL) begin
                        n_err   = ST_MALFORMED;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_phase = PH_WANT_U;
                    end
                end
                PH_WANT_U: begin
                    if (c != CH_U) begin
                        n_err   = ST_MALFORMED;
                        n_phase = PH_PLAIN;
                    end else begin
                        n_phase = PH_HEX_LO;
                        n_acc   = '0;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    n_phase = PH_PLAIN;
                    if (c == CH_BSL) begin
                        n_phase = PH_ESC;
                    end else begin
                        enc.b[0] = c;
                        enc.n    = 3'd1;
                    end
                end
            endcase
        end

        // Capacity check over the whole expansion of this byte
        sum = {1'b0, r_bw} + {14'd0, enc.n};
        if (enc.n != 3'd0) begin
            if (sum > {1'b0, r_cap}) begin
                n_err   = ST_CAPACITY;
                n_phase = PH_PLAIN;
                enc.n   = 3'd0;
            end else begin
                n_bw = sum[15:0];
            end
        end

        // String closed inside an escape
        if (i_in.final_byte && n_phase != PH_PLAIN) begin
            if (n_err == ST_OK) begin
                n_err = ST_MALFORMED;
            end
            n_phase = PH_PLAIN;
            enc.n   = 3'd0;
        end
    end

    assign o_grp.bytes   = enc.b;
    assign o_grp.n_bytes = enc.n;
    assign o_grp.last    = i_in.final_byte;
    assign o_grp.status  = n_err;
    assign o_push        = i_accept && (enc.n != 3'd0 || i_in.final_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 16'hFFFF;
            r_phase <= PH_PLAIN;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_hs    <= '0;
            r_bw    <= '0;
            r_err   <= ST_OK;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_accept && i_in.final_byte) begin
                r_phase <= PH_PLAIN;
                r_acc   <= '0;
                r_cnt   <= '0;
                r_hs    <= '0;
                r_bw    <= '0;
                r_err   <= ST_OK;
            end else if (i_accept) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_hs    <= n_hs;
                r_bw    <= n_bw;
                r_err   <= n_err;
            end
        end
    end

endmodule

/* rtl/core/jsu_fifo.sv */
module jsu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_grp i_data,
    input  logic          i_pop,
    output jsu_pkg::t_grp o_data,
    output jsu_pkg::t_q_st o_st
);
    import jsu_pkg::*;

    t_grp           r_mem [QDepth];
    logic [QAw-1:0] r_wp, r_rp;
    logic [QAw:0]   r_cnt;

    assign o_st.full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_st.empty = (r_cnt == '0);
    assign o_data     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAw'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAw'(1);
            end
            r_cnt <= r_cnt + (QAw+1)'(i_push) - (QAw+1)'(i_pop);
        end
    end

endmodule

/* rtl/core/jsu_back.sv */
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  jsu_pkg::t_grp i_grp,
    input  logic          i_grp_valid,
    output logic          o_grp_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_out o_out
);
    import jsu_pkg::*;

    logic [1:0] r_k;
    logic       r_valid;
    t_out       r_out;
    t_out       n_out;
    logic       load;
    logic       at_end;

    assign load      = i_grp_valid && (!r_valid || i_pop);
    assign at_end    = (i_grp.n_bytes == 3'd0) || ({1'b0, r_k} == i_grp.n_bytes - 3'd1);
    assign o_grp_pop = load && at_end;

    always_comb begin
        if (i_grp.n_bytes == 3'd0) begin
            n_out.out_byte    = '0;
            n_out.byte_valid  = 1'b0;
            n_out.string_done = 1'b1;
            n_out.status      = i_grp.status;
        end else begin
            n_out.out_byte    = i_grp.bytes[r_k];
            n_out.byte_valid  = 1'b1;
            n_out.string_done = i_grp.last && at_end;
            n_out.status      = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= at_end ? 2'd0 : r_k + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_valid;
    assign o_out   = r_out;

endmodule
